@@ rtl/core/ghp_pkg.sv @@
`default_nettype none

package ghp_pkg;

  // Field widths fixed by the transaction format.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Requests from the sequencer to the free-slot queue.
  typedef struct packed {
    logic push;
    logic pop;
  } ghp_fifo_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ghp_ram.sv @@
`default_nettype none

module ghp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ghp_free_fifo.sv @@
`default_nettype none

// Queue of freed slot indexes. A pop presents the head entry on pop_slot in the
// next cycle.
module ghp_free_fifo import ghp_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ghp_fifo_ctl_t    ctl,
  input  wire logic [IDX_W-1:0] push_slot,
  output logic      [IDX_W-1:0] pop_slot,
  output logic                  nonempty
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    unique case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign nonempty = (count_r != '0);

  ghp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail_r),
    .wdata (push_slot),
    .re    (ctl.pop),
    .raddr (head_r),
    .rdata (pop_slot)
  );

endmodule

`default_nettype wire

@@ rtl/core/generational_handle_pool_unit.sv @@
`default_nettype none

// Channel   Direction  tdata fields (low bit first)                      tuser / tlast
// in_*      slave      operation, object_ref, slot_number,               none
//                      handle_generation
// out_*     master     status, given_slot, given_generation, found_ref   none
//
// The pool handles one transaction at a time. An item whose outcome is known
// from the request alone (null reference, fresh slot, exhausted pool, slot out
// of range, unknown operation) goes straight to S_EMIT; unregister and lookup
// pass through S_CHECK first, because the reference and generation memories
// have a registered read port; a register that reuses a freed slot passes
// through S_POP and S_BUMP, since the queue read must finish before the generation is read.
// Reset is synchronous and active low; it clears the queue pointers, the fresh
// slot counter and the sequencer. The memories are not cleared: every entry
// read was written first. A finished result waits in an output register, so a
// new request is taken while out_tready is low; only the next result waits.
module generational_handle_pool_unit import ghp_pkg::*; #(
  parameter int SLOT_COUNT = 256,
  parameter int GEN_BITS   = 16,
  parameter int REF_BITS   = 32,
  localparam int SLOT_W      = $clog2(SLOT_COUNT),
  localparam int IN_W        = OP_W + REF_BITS + SLOT_W + GEN_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = STATUS_W + SLOT_W + GEN_BITS + REF_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // operation, object_ref, slot_number, handle_generation, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // status, given_slot, given_generation, found_ref, zero fill
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
  localparam int IN_OBJ_LSB   = OP_W;
  localparam int IN_SLOT_LSB  = OP_W + REF_BITS;
  localparam int IN_GEN_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int OUT_SLOT_LSB = STATUS_W;
  localparam int OUT_GEN_LSB  = STATUS_W + SLOT_W;
  localparam int OUT_REF_LSB  = OUT_GEN_LSB + GEN_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_POP   = 3'd1;  // freed slot index arrives from the queue
  localparam logic [2:0] S_BUMP  = 3'd2;  // old generation arrives, write back
  localparam logic [2:0] S_CHECK = 3'd3;  // reference and generation arrive
  localparam logic [2:0] S_EMIT  = 3'd4;  // hand the result to the output register

  // Unpacked request fields.
  logic [OP_W-1:0]     in_op;
  logic [REF_BITS-1:0] in_obj;
  logic [SLOT_W-1:0]   in_slot;
  logic [GEN_BITS-1:0] in_hgen;

  assign in_op   = in_tdata[OP_W-1:0];
  assign in_obj  = in_tdata[IN_OBJ_LSB +: REF_BITS];
  assign in_slot = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_hgen = in_tdata[IN_GEN_LSB +: GEN_BITS];

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    fresh_r, fresh_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [REF_BITS-1:0] obj_r, obj_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [GEN_BITS-1:0] hgen_r, hgen_nxt;

  // Result waiting for the output register.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [GEN_BITS-1:0] res_gen_r, res_gen_nxt;
  logic [REF_BITS-1:0] res_ref_r, res_ref_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [GEN_BITS-1:0] out_gen_r;
  logic [REF_BITS-1:0] out_ref_r;

  // Memory ports.
  logic                gen_we, gen_re;
  logic [SLOT_W-1:0]   gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0] gen_wdata, gen_rdata, gen_bump;
  logic                ref_we, ref_re;
  logic [SLOT_W-1:0]   ref_waddr, ref_raddr;
  logic [REF_BITS-1:0] ref_wdata, ref_rdata;

  ghp_fifo_ctl_t       fifo_ctl;
  logic [SLOT_W-1:0]   fifo_pop_slot;
  logic                fifo_nonempty;

  logic in_fire;
  logic in_range;
  logic out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // Slots at or past the fresh counter were never handed out.
  assign in_range  = (CNT_W'(in_slot) < fresh_r);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign gen_bump  = gen_rdata + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    fresh_nxt      = fresh_r;
    op_nxt         = op_r;
    obj_nxt        = obj_r;
    slot_nxt       = slot_r;
    hgen_nxt       = hgen_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_gen_nxt    = res_gen_r;
    res_ref_nxt    = res_ref_r;
    fifo_ctl       = '0;
    gen_we         = 1'b0;
    gen_waddr      = slot_r;
    gen_wdata      = gen_bump;
    gen_re         = 1'b0;
    gen_raddr      = in_slot;
    ref_we         = 1'b0;
    ref_waddr      = slot_r;
    ref_wdata      = obj_r;
    ref_re         = 1'b0;
    ref_raddr      = in_slot;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_op;
          obj_nxt        = in_obj;
          slot_nxt       = in_slot;
          hgen_nxt       = in_hgen;
          res_status_nxt = ST_IGNORED;
          res_slot_nxt   = '0;
          res_gen_nxt    = '0;
          res_ref_nxt    = '0;
          state_nxt      = S_EMIT;
          unique case (in_op)
            OP_REGISTER: begin
              priority if (in_obj == '0) begin
                res_status_nxt = ST_IGNORED;
              end else if (fifo_nonempty) begin
                fifo_ctl.pop = 1'b1;
                state_nxt    = S_POP;
              end else if (fresh_r != CNT_W'(SLOT_COUNT)) begin
                // A fresh slot starts from generation zero, so it gets one.
                gen_we         = 1'b1;
                gen_waddr      = fresh_r[SLOT_W-1:0];
                gen_wdata      = GEN_BITS'(1);
                ref_we         = 1'b1;
                ref_waddr      = fresh_r[SLOT_W-1:0];
                ref_wdata      = in_obj;
                fresh_nxt      = fresh_r + 1'b1;
                res_status_nxt = ST_OK;
                res_slot_nxt   = fresh_r[SLOT_W-1:0];
                res_gen_nxt    = GEN_BITS'(1);
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_UNREGISTER: begin
              if (in_range) begin
                ref_re    = 1'b1;
                state_nxt = S_CHECK;
              end
            end
            OP_LOOKUP: begin
              if (in_range) begin
                ref_re    = 1'b1;
                gen_re    = 1'b1;
                state_nxt = S_CHECK;
              end else begin
                res_status_nxt = ST_MISS;
              end
            end
            default: begin
              res_status_nxt = ST_IGNORED;
            end
          endcase
        end
      end
      S_POP: begin
        gen_re    = 1'b1;
        gen_raddr = fifo_pop_slot;
        slot_nxt  = fifo_pop_slot;
        state_nxt = S_BUMP;
      end
      S_BUMP: begin
        gen_we         = 1'b1;
        ref_we         = 1'b1;
        res_status_nxt = ST_OK;
        res_slot_nxt   = slot_r;
        res_gen_nxt    = gen_bump;
        state_nxt      = S_EMIT;
      end
      S_CHECK: begin
        if (op_r == OP_UNREGISTER) begin
          // An empty slot has a null reference; freeing it again is ignored.
          if (ref_rdata != '0) begin
            fifo_ctl.push  = 1'b1;
            ref_we         = 1'b1;
            ref_wdata      = '0;
            res_status_nxt = ST_OK;
          end
        end else begin
          if ((ref_rdata != '0) && (gen_rdata == hgen_r)) begin
            res_status_nxt = ST_OK;
            res_ref_nxt    = ref_rdata;
          end else begin
            res_status_nxt = ST_MISS;
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    obj_r        <= obj_nxt;
    slot_r       <= slot_nxt;
    hgen_r       <= hgen_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_gen_r    <= res_gen_nxt;
    res_ref_r    <= res_ref_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_gen_r    <= res_gen_r;
      out_ref_r    <= res_ref_r;
    end
  end

  always_comb begin
    out_tdata                             = '0;
    out_tdata[STATUS_W-1:0]               = out_status_r;
    out_tdata[OUT_SLOT_LSB +: SLOT_W]     = out_slot_r;
    out_tdata[OUT_GEN_LSB +: GEN_BITS]    = out_gen_r;
    out_tdata[OUT_REF_LSB +: REF_BITS]    = out_ref_r;
  end

  assign out_tvalid = out_valid_r;

  ghp_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  ghp_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (ref_re),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  ghp_free_fifo #(
    .DEPTH (SLOT_COUNT)
  ) u_free_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .push_slot (slot_r),
    .pop_slot  (fifo_pop_slot),
    .nonempty  (fifo_nonempty)
  );

endmodule

`default_nettype wire

@@ rtl/core/ghp_checker.sv @@
`default_nettype none

module ghp_checker import ghp_pkg::*; #(
  parameter int SLOT_COUNT = 256,
  parameter int GEN_BITS   = 16,
  parameter int REF_BITS   = 32,
  localparam int SLOT_W      = $clog2(SLOT_COUNT),
  localparam int OUT_W       = STATUS_W + SLOT_W + GEN_BITS + REF_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       in_fire, out_fire;
  logic [1:0] pend_r, pend_nxt;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Requests taken whose results have not yet been delivered.
  always_comb begin
    pend_nxt = pend_r + 2'(in_fire) - 2'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // No result survives reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Every result answers an earlier request, and at most one request is in
  // work while another result waits.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (pend_r != 2'd0))
    else $error("result without a request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // Any outcome but success carries no slot, generation or reference.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STATUS_W-1:0] != ST_OK)
      |-> (out_tdata[OUT_TDATA_W-1:STATUS_W] == '0))
    else $error("failed result carries payload");

endmodule

bind generational_handle_pool_unit ghp_checker #(
  .SLOT_COUNT (SLOT_COUNT),
  .GEN_BITS   (GEN_BITS),
  .REF_BITS   (REF_BITS)
) u_ghp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ tb/sv/ghp_handle_checker.sv @@
`timescale 1ns / 1ps

module ghp_handle_checker import ghp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  output int               mismatch_count,
  output int               outstanding
);

  localparam int POOL_SLOTS = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [15:0] gen;
    logic [31:0] oref;
  } pool_result_t;

  // Shadow copy of the pool. A slot holds an object while its reference is nonzero.
  logic [15:0]  slot_gen [POOL_SLOTS];
  logic [31:0]  slot_ref [POOL_SLOTS];
  logic [7:0]   freed_slots [$];
  int           fresh_used;
  pool_result_t awaited_results [$];
  pool_result_t want;
  pool_result_t got;

  function automatic pool_result_t apply_pool_request(input logic [1:0] op,
                                                      input logic [31:0] oref,
                                                      input logic [7:0] slot,
                                                      input logic [15:0] hgen);
    pool_result_t r;
    int s;
    r = '0;
    case (op)
      OP_REGISTER: begin
        if (oref == '0) begin
          r.status = ST_IGNORED;
        end else if (freed_slots.size() == 0 && fresh_used >= POOL_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (freed_slots.size() > 0) begin
            s = int'(freed_slots.pop_front());
          end else begin
            s = fresh_used;
            fresh_used++;
          end
          slot_gen[s] = slot_gen[s] + 16'd1;
          slot_ref[s] = oref;
          r.status = ST_OK;
          r.slot   = s[7:0];
          r.gen    = slot_gen[s];
        end
      end
      OP_UNREGISTER: begin
        if (int'(slot) >= fresh_used || slot_ref[slot] == '0) begin
          r.status = ST_IGNORED;
        end else begin
          freed_slots = {freed_slots, slot};
          slot_ref[slot] = '0;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (int'(slot) >= fresh_used || slot_ref[slot] == '0 || slot_gen[slot] != hgen) begin
          r.status = ST_MISS;
        end else begin
          r.status = ST_OK;
          r.oref   = slot_ref[slot];
        end
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slot_gen[i] = '0;
        slot_ref[i] = '0;
      end
      freed_slots.delete();
      awaited_results.delete();
      fresh_used     = 0;
      mismatch_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results = {awaited_results,
                           apply_pool_request(in_tdata[1:0], in_tdata[33:2],
                                              in_tdata[41:34], in_tdata[57:42])};
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.slot   = out_tdata[9:2];
        got.gen    = out_tdata[25:10];
        got.oref   = out_tdata[57:26];
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unrequested result: status %0d slot %0d gen %0d ref %h",
                     $time, got.status, got.slot, got.gen, got.oref);
        end else begin
          want = awaited_results.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected status %0d slot %0d gen %0d ref %h, %s",
                       $time, want.status, want.slot, want.gen, want.oref,
                       $sformatf("got status %0d slot %0d gen %0d ref %h",
                                 got.status, got.slot, got.gen, got.oref));
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ tb/sv/generational_handle_pool_unit_tb.sv @@
`timescale 1ns / 1ps

module generational_handle_pool_unit_tb;
  import ghp_pkg::*;

  // The fourth operation code is not defined by the pool; it must be ignored.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Number of randomly chosen requests.
  localparam int RANDOM_COUNT = 420;
  // Enough registrations to use up every free slot, whatever the pool held before.
  localparam int FILL_COUNT = 260;
  // Reuse one slot this many times while every other slot is taken.
  localparam int SPIN_ROUNDS = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // operation, object_ref, slot_number, handle_generation, zero fill
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // status, given_slot, given_generation, found_ref, zero fill
  logic [63:0] out_tdata;

  logic        idle_enable = 1'b1;
  int          ready_hold = 0;
  int          quiet_cycles = 0;
  int          mismatch_count;
  int          outstanding;

  initial begin
    forever #4 clk = ~clk;
  end

  generational_handle_pool_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ghp_handle_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Result side back-pressure: random bursts with out_tready low while idling is enabled.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("generational_handle_pool_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until the pool takes it. Returns right after
  // the accepting edge so the next request can follow without a bubble.
  task automatic issue_request(input logic [1:0] op, input logic [31:0] oref,
                               input logic [7:0] slot, input logic [15:0] hgen);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, hgen, slot, oref, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int          pick;
    logic [1:0]  op;
    logic [31:0] oref;
    logic [7:0]  slot;
    logic [15:0] hgen;
    logic [7:0]  spin_slot;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on an empty pool. A register with a null reference is
    // dropped, and nothing can be freed or found before any slot is handed out.
    issue_request(OP_REGISTER,   32'h0,        8'd0,   16'd0);
    issue_request(OP_LOOKUP,     32'h0,        8'd0,   16'd0);
    issue_request(OP_UNREGISTER, 32'h0,        8'd0,   16'd0);
    issue_request(OP_UNKNOWN,    32'h0,        8'd0,   16'd0);
    issue_request(OP_REGISTER,   32'hFFFFFFFF, 8'd0,   16'd0);
    issue_request(OP_REGISTER,   32'h00000001, 8'd255, 16'hFFFF);
    issue_request(OP_LOOKUP,     32'h0,        8'd0,   16'd1);
    // A wrong generation and a slot beyond the handed-out range both miss.
    issue_request(OP_LOOKUP,     32'h0,        8'd0,   16'd2);
    issue_request(OP_LOOKUP,     32'hFFFFFFFF, 8'd255, 16'hFFFF);
    issue_request(OP_UNREGISTER, 32'hFFFFFFFF, 8'd0,   16'hFFFF);
    // Freeing the same slot twice is ignored; looking it up afterwards misses.
    issue_request(OP_UNREGISTER, 32'h0,        8'd0,   16'd0);
    issue_request(OP_LOOKUP,     32'h0,        8'd0,   16'd1);
    // The freed slot comes back from the queue with a bumped generation.
    issue_request(OP_REGISTER,   32'hA5A55A5A, 8'd0,   16'd0);
    issue_request(OP_LOOKUP,     32'h0,        8'd0,   16'd2);
    issue_request(OP_UNREGISTER, 32'h0,        8'd255, 16'd0);
    issue_request(OP_UNKNOWN,    32'hFFFFFFFF, 8'd255, 16'hFFFF);
    issue_request(OP_UNREGISTER, 32'h0,        8'd1,   16'd0);
    issue_request(OP_REGISTER,   32'h5A5AA5A5, 8'd0,   16'd0);
    issue_request(OP_LOOKUP,     32'h0,        8'd1,   16'd2);

    // Random part. Slots and generations are mostly drawn from the small values
    // the pool actually holds, so lookups and unregisters hit often.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 50 == 0) idle_enable <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = OP_REGISTER;
      else if (pick < 63) op = OP_UNREGISTER;
      else if (pick < 95) op = OP_LOOKUP;
      else                op = OP_UNKNOWN;
      pick = $urandom_range(0, 19);
      if (pick < 2)       oref = 32'h0;
      else if (pick == 2) oref = 32'hFFFFFFFF;
      else                oref = $urandom;
      slot = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
      hgen = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      issue_request(op, oref, slot, hgen);
    end

    // Last part, without idling. Fill the pool until it reports full, then
    // cycle one slot through free and register a number of times.
    // With every slot taken, the slot just freed is the only one available.
    idle_enable <= 1'b0;
    for (int n = 0; n < FILL_COUNT; n++)
      issue_request(OP_REGISTER, $urandom | 32'h1, 8'($urandom), 16'($urandom));
    spin_slot = 8'($urandom_range(0, 255));
    for (int n = 0; n < SPIN_ROUNDS; n++) begin
      issue_request(OP_UNREGISTER, 32'h0, spin_slot, 16'd0);
      issue_request(OP_REGISTER, $urandom | 32'h1, spin_slot, 16'($urandom));
      if (n % 8 == 0)
        issue_request(OP_LOOKUP, 32'h0, spin_slot, 16'($urandom_range(0, 7)));
    end
    issue_request(OP_REGISTER, 32'hFFFFFFFF, 8'd0, 16'd0);

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("generational_handle_pool_unit_tb OK");
    end else begin
      $display("generational_handle_pool_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
